### rtl/kmd_pkg.sv
// Shared types and constants for the key matrix debouncer.
// Used by every module of the block but kmd_ram; depends on nothing else.
`timescale 1ns / 1ps

package kmd_pkg;

   localparam int ROWS      = 8;
   localparam int COLS      = 16;
   localparam int KEYS      = ROWS * COLS;
   localparam int KEY_W     = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int ROW_SEL_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam int ROW_W     = 3;
   localparam int COL_W     = 4;
   localparam int BITS_W    = 16;
   localparam int HIST_W    = 8;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_THRESHOLD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF_DELAY  = 2'd2;

   localparam logic [CFG_W-1:0] DOWN_THRESHOLD_RESET = 8'd224;
   localparam logic [CFG_W-1:0] UP_THRESHOLD_RESET   = 8'd8;
   localparam logic [CFG_W-1:0] HOLDOFF_DELAY_RESET  = 8'd5;

   typedef struct packed {
      logic [CFG_W-1:0] down_threshold;
      logic [CFG_W-1:0] up_threshold;
      logic [CFG_W-1:0] holdoff_delay;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [ROW_SEL_W-1:0] row;
      logic [COL_W-1:0]     col;
      logic                 level;
      logic                 in_range;
   } item_type;

   typedef struct packed {
      logic [HIST_W-1:0] history;
      logic [HIST_W-1:0] holdoff;
   } key_state_type;

   localparam int KEY_STATE_W = $bits(key_state_type);

   typedef struct packed {
      logic              key_down;
      logic              key_changed;
      logic [BITS_W-1:0] row_bits;
      logic              row_active;
   } result_type;

endpackage

### rtl/kmd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds no reset.
`timescale 1ns / 1ps

module kmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/kmd_front.sv
// Front end: accepts raw key samples, classifies them and queues them.
// Depends on kmd_pkg.
`timescale 1ns / 1ps

module kmd_front import kmd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [ROW_W-1:0] req_row_index,
   input  logic [COL_W-1:0] req_col_index,
   input  logic             req_pressed,
   output logic             item_valid,
   output item_type         item,
   input  logic             item_pop
);

   item_type   q_ff [2];
   item_type   entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   assign req_ready  = (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      entry_in.in_range = (int'(req_row_index) < ROWS) && (int'(req_col_index) < COLS);
      entry_in.key      = KEY_W'(int'(req_row_index) * COLS + int'(req_col_index));
      entry_in.row      = ROW_SEL_W'(req_row_index);
      entry_in.col      = req_col_index;
      entry_in.level    = req_pressed;
      wr_ptr_in         = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in         = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in            = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

### rtl/kmd_back.sv
// Back end: per-key read-modify-write of history and hold-off with forwarding,
// row bitmap update and the result queue. Depends on kmd_pkg and kmd_ram.
`timescale 1ns / 1ps

module kmd_back import kmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              item_valid,
   input  item_type          item,
   output logic              item_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_key_down,
   output logic              rsp_key_changed,
   output logic [BITS_W-1:0] rsp_row_bits,
   output logic              rsp_row_active
);

   logic               issue;
   logic               room;
   logic               fwd_hit;

   logic               b_valid_ff, b_valid_in;
   item_type           b_item_ff;
   logic               b_fwd_ff;
   key_state_type      b_fwd_data_ff;
   logic               b_known_ff;
   logic [KEYS-1:0]    key_known_ff;
   logic [BITS_W-1:0]  row_state_ff [ROWS];

   logic [KEY_STATE_W-1:0] ram_rdata;
   key_state_type      cur;
   key_state_type      b_new;
   logic               b_write;
   logic [BITS_W-1:0]  row_prior;
   logic [BITS_W-1:0]  row_bits_in;
   logic [HIST_W-1:0]  hist;
   result_type         result;

   result_type         out_q_ff [2];
   logic               out_wr_ptr_ff, out_wr_ptr_in;
   logic               out_rd_ptr_ff, out_rd_ptr_in;
   logic [1:0]         out_cnt_ff, out_cnt_in;
   logic               out_push;
   logic               out_pop;

   kmd_ram #(
      .WIDTH (KEY_STATE_W),
      .DEPTH (KEYS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (b_write),
      .wr_addr (b_item_ff.key),
      .wr_data (b_new),
      .rd_en   (issue),
      .rd_addr (item.key),
      .rd_data (ram_rdata)
   );

   assign out_push = b_valid_ff;
   assign out_pop  = rsp_valid && rsp_ready;
   assign room     = (3'({1'b0, out_cnt_ff}) + 3'({2'b0, b_valid_ff}))
                     < (3'd2 + 3'({2'b0, out_pop}));
   assign issue    = item_valid && room;
   assign item_pop = issue;
   assign b_valid_in = issue;
   assign b_write  = b_valid_ff && b_item_ff.in_range;
   assign fwd_hit  = b_write && (b_item_ff.key == item.key);

   always_comb begin
      if (b_fwd_ff) begin
         cur = b_fwd_data_ff;
      end else if (b_known_ff) begin
         cur = key_state_type'(ram_rdata);
      end else begin
         cur = '0;
      end
      hist        = {b_item_ff.level, cur.history[HIST_W-1:1]};
      row_prior   = row_state_ff[b_item_ff.row];
      row_bits_in = row_prior;
      b_new.history = hist;
      b_new.holdoff = cur.holdoff;
      if ((cur.holdoff != '0) && !row_prior[b_item_ff.col]) begin
         b_new.holdoff = cur.holdoff - 1'b1;
      end else if (hist > cfg.down_threshold) begin
         row_bits_in[b_item_ff.col] = 1'b1;
         b_new.holdoff = cfg.holdoff_delay;
      end else if (hist < cfg.up_threshold) begin
         row_bits_in[b_item_ff.col] = 1'b0;
      end
      if (b_item_ff.in_range) begin
         result.key_down    = row_bits_in[b_item_ff.col];
         result.key_changed = row_bits_in[b_item_ff.col] ^ row_prior[b_item_ff.col];
         result.row_bits    = row_bits_in;
         result.row_active  = (row_bits_in != '0);
      end else begin
         result = '0;
      end
      out_wr_ptr_in = out_push ? ~out_wr_ptr_ff : out_wr_ptr_ff;
      out_rd_ptr_in = out_pop ? ~out_rd_ptr_ff : out_rd_ptr_ff;
      out_cnt_in    = out_cnt_ff + {1'b0, out_push} - {1'b0, out_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         key_known_ff  <= '0;
         out_wr_ptr_ff <= 1'b0;
         out_rd_ptr_ff <= 1'b0;
         out_cnt_ff    <= 2'd0;
         for (int i = 0; i < ROWS; i++) begin
            row_state_ff[i] <= '0;
         end
      end else begin
         b_valid_ff    <= b_valid_in;
         out_wr_ptr_ff <= out_wr_ptr_in;
         out_rd_ptr_ff <= out_rd_ptr_in;
         out_cnt_ff    <= out_cnt_in;
         if (b_write) begin
            key_known_ff[b_item_ff.key] <= 1'b1;
            row_state_ff[b_item_ff.row] <= row_bits_in;
         end
      end
      if (issue) begin
         b_item_ff     <= item;
         b_fwd_ff      <= fwd_hit;
         b_fwd_data_ff <= b_new;
         b_known_ff    <= key_known_ff[item.key];
      end
      if (out_push) begin
         out_q_ff[out_wr_ptr_ff] <= result;
      end
   end

   assign rsp_valid       = (out_cnt_ff != 2'd0);
   assign rsp_key_down    = out_q_ff[out_rd_ptr_ff].key_down;
   assign rsp_key_changed = out_q_ff[out_rd_ptr_ff].key_changed;
   assign rsp_row_bits    = out_q_ff[out_rd_ptr_ff].row_bits;
   assign rsp_row_active  = out_q_ff[out_rd_ptr_ff].row_active;

endmodule

### rtl/key_matrix_debounce_top.sv
// Key matrix debouncer top level: configuration registers, front end and back end.
// A sample passes the front-end queue, the back-end stage register and the result queue.
// Throughput: one sample per cycle while the result queue has room (state RAM forwarding).
// Reset is synchronous and active high: it empties both queues, clears the row bitmaps
// and per-key valid bits at once, and restores the register defaults; no clearing pass.
`timescale 1ns / 1ps

module key_matrix_debounce_top import kmd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ROW_W-1:0]     req_row_index,
   input  logic [COL_W-1:0]     req_col_index,
   input  logic                 req_pressed,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_key_down,
   output logic                 rsp_key_changed,
   output logic [BITS_W-1:0]    rsp_row_bits,
   output logic                 rsp_row_active,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     item_valid;
   item_type item;
   logic     item_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DOWN_THRESHOLD: cfg_in.down_threshold = csr_wdata;
            CSR_UP_THRESHOLD:   cfg_in.up_threshold   = csr_wdata;
            CSR_HOLDOFF_DELAY:  cfg_in.holdoff_delay  = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.down_threshold <= DOWN_THRESHOLD_RESET;
         cfg_ff.up_threshold   <= UP_THRESHOLD_RESET;
         cfg_ff.holdoff_delay  <= HOLDOFF_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kmd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_pressed   (req_pressed),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   kmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_down    (rsp_key_down),
      .rsp_key_changed (rsp_key_changed),
      .rsp_row_bits    (rsp_row_bits),
      .rsp_row_active  (rsp_row_active)
   );

endmodule

### rtl/kmd_checker.sv
// Port-level checks for the key matrix debouncer, bound to the top level.
// Depends on kmd_pkg and key_matrix_debounce_top.
`timescale 1ns / 1ps

module kmd_checker import kmd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_key_down,
   input logic                 rsp_key_changed,
   input logic [BITS_W-1:0]    rsp_row_bits,
   input logic                 rsp_row_active
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_down)
         && $stable(rsp_key_changed) && $stable(rsp_row_bits) && $stable(rsp_row_active))
      else $error("Stalled response transaction changed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response offered right after reset.");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("Sample transaction refused right after reset.");

   a_active_matches_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_row_bits != '0) == rsp_row_active))
      else $error("Row active flag disagrees with the row bitmap.");

   a_down_in_active_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_down |-> rsp_row_active)
      else $error("Key reported down in an idle row.");

endmodule

bind key_matrix_debounce_top kmd_checker u_kmd_checker (.*);

### sim/key_matrix_debounce_top_tb.sv
// Self-checking testbench for key_matrix_debounce_top: drives key samples through
// valid/ready, predicts every result in a scoreboard class and checks it field by field.
// Depends on kmd_pkg and the key_matrix_debounce_top RTL.
`timescale 1ns / 1ps

import kmd_pkg::*;

class debounce_scoreboard;
   logic [CFG_W-1:0]  down_level;
   logic [CFG_W-1:0]  up_level;
   logic [CFG_W-1:0]  holdoff_reload;
   logic [HIST_W-1:0] history [KEYS];
   logic [HIST_W-1:0] holdoff [KEYS];
   logic [BITS_W-1:0] row_map [ROWS];
   result_type        key_states_due [$];
   int                errors;
   int                results_seen;

   function new();
      down_level     = DOWN_THRESHOLD_RESET;
      up_level       = UP_THRESHOLD_RESET;
      holdoff_reload = HOLDOFF_DELAY_RESET;
      foreach (history[k]) begin
         history[k] = '0;
         holdoff[k] = '0;
      end
      foreach (row_map[r]) row_map[r] = '0;
      errors       = 0;
      results_seen = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      case (index)
         CSR_DOWN_THRESHOLD: down_level = value;
         CSR_UP_THRESHOLD:   up_level = value;
         CSR_HOLDOFF_DELAY:  holdoff_reload = value;
         default: ;
      endcase
   endfunction

   function int pending();
      return key_states_due.size();
   endfunction

   // Applies one accepted sample transaction to the model state and queues its result.
   function void predict_sample(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic level);
      result_type        res;
      int                key;
      logic [BITS_W-1:0] prior;
      logic [BITS_W-1:0] bit_sel;
      res = '0;
      if (row < ROWS && col < COLS) begin
         key     = row * COLS + col;
         bit_sel = BITS_W'(1) << col;
         prior   = row_map[row];
         history[key] = {level, history[key][HIST_W-1:1]};
         if (holdoff[key] != 0 && (prior & bit_sel) == 0) begin
            holdoff[key] = holdoff[key] - 1'b1;
         end else if (history[key] > down_level) begin
            row_map[row] = prior | bit_sel;
            holdoff[key] = holdoff_reload;
         end else if (history[key] < up_level) begin
            row_map[row] = prior & ~bit_sel;
         end
         res.key_down    = |(row_map[row] & bit_sel);
         res.key_changed = |((row_map[row] ^ prior) & bit_sel);
         res.row_bits    = row_map[row];
         res.row_active  = |row_map[row];
      end
      key_states_due.push_back(res);
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
   endtask

   task check_result(result_type got);
      result_type want;
      if (key_states_due.size() == 0) begin
         report($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
         want = key_states_due.pop_front();
         if (got.key_down !== want.key_down)
            report($sformatf("result %0d key_down %b, expected %b",
                             results_seen, got.key_down, want.key_down));
         if (got.key_changed !== want.key_changed)
            report($sformatf("result %0d key_changed %b, expected %b",
                             results_seen, got.key_changed, want.key_changed));
         if (got.row_bits !== want.row_bits)
            report($sformatf("result %0d row_bits %h, expected %h",
                             results_seen, got.row_bits, want.row_bits));
         if (got.row_active !== want.row_active)
            report($sformatf("result %0d row_active %b, expected %b",
                             results_seen, got.row_active, want.row_active));
      end
      results_seen++;
   endtask
endclass

module key_matrix_debounce_top_tb;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [ROW_W-1:0]     req_row_index;
   logic [COL_W-1:0]     req_col_index;
   logic                 req_pressed;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_key_down;
   logic                 rsp_key_changed;
   logic [BITS_W-1:0]    rsp_row_bits;
   logic                 rsp_row_active;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   debounce_scoreboard sb;
   bit                 no_idle = 1'b0;
   bit                 stall_request = 1'b0;

   key_matrix_debounce_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_pressed      (req_pressed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_down     (rsp_key_down),
      .rsp_key_changed  (rsp_key_changed),
      .rsp_row_bits     (rsp_row_bits),
      .rsp_row_active   (rsp_row_active),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("[key_matrix_debounce_top] ERROR");
      $finish;
   end

   function automatic bit idle_now();
      return !no_idle && $urandom_range(99) < 30;
   endfunction

   task automatic send_sample(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic level);
      if (idle_now()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_now());
      end
      req_valid     <= 1'b1;
      req_row_index <= row;
      req_col_index <= col;
      req_pressed   <= level;
      do @(posedge clock); while (!req_ready);
      sb.predict_sample(row, col, level);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(logic [CFG_W-1:0] down, logic [CFG_W-1:0] up,
                             logic [CFG_W-1:0] delay);
      logic [CFG_W-1:0] values [3];
      values[0] = down;
      values[1] = up;
      values[2] = delay;
      for (int i = 0; i < 3; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_IDX_W'(i);
         csr_wdata        <= values[i];
         @(posedge clock);
         sb.write_reg(CSR_IDX_W'(i), values[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Mostly bursts of one level on one key with some contact bounce, so keys really
   // get pressed and released; the rest are isolated samples on random keys.
   task automatic run_phase(int count);
      int               sent;
      int               burst_len;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             level;
      sent = 0;
      while (sent < count) begin
         row   = ($urandom_range(99) < 50) ? ROW_W'($urandom_range(1)) : ROW_W'($urandom);
         col   = COL_W'($urandom);
         level = 1'($urandom);
         if ($urandom_range(99) < 70) begin
            burst_len = $urandom_range(12, 4);
            for (int i = 0; i < burst_len; i++) begin
               send_sample(row, col, level ^ ($urandom_range(99) < 10));
               sent++;
            end
         end else begin
            send_sample(row, col, level);
            sent++;
         end
      end
   endtask

   initial begin
      result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.key_down    = rsp_key_down;
            got.key_changed = rsp_key_changed;
            got.row_bits    = rsp_row_bits;
            got.row_active  = rsp_row_active;
            sb.check_result(got);
         end
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            rsp_ready <= !idle_now();
         end
      end
   end

   initial begin
      sb = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_row_index    <= '0;
      req_col_index    <= '0;
      req_pressed      <= 1'b0;
      rsp_ready        <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Press, release and hold-off countdown on one corner key, then the opposite corner.
      repeat (8) send_sample(ROW_W'(0), COL_W'(0), 1'b1);
      repeat (5) send_sample(ROW_W'(0), COL_W'(0), 1'b0);
      repeat (5) send_sample(ROW_W'(0), COL_W'(0), 1'b1);
      repeat (7) send_sample(ROW_W'(ROWS - 1), COL_W'(COLS - 1), 1'b1);
      wait_idle();

      set_config(8'd0, 8'd255, 8'd0);
      run_phase(295);
      wait_idle();

      set_config(8'd224, 8'd8, 8'd5);
      no_idle = 1'b1;
      run_phase(295);
      no_idle = 1'b0;
      wait_idle();

      set_config(CFG_W'($urandom_range(255)), CFG_W'($urandom_range(255)),
                 CFG_W'($urandom_range(12)));
      stall_request = 1'b1;
      run_phase(295);
      wait_idle();

      set_config(8'd255, 8'd0, 8'd255);
      run_phase(295);
      wait_idle();

      set_config(CFG_W'($urandom_range(255)), CFG_W'($urandom_range(255)),
                 CFG_W'($urandom_range(12)));
      run_phase(295);
      wait_idle();

      set_config(8'd127, 8'd128, 8'd1);
      run_phase(295);
      wait_idle();
      repeat (6) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[key_matrix_debounce_top] OK");
      end else begin
         $display("[key_matrix_debounce_top] ERROR");
      end
      $finish;
   end

endmodule
